// ===== rtl/core/bdlp_pkg.sv =====
// bdlp_pkg: shared types and constants of the button debounce / long-press block
// used by the lane, the merge stage, the top level and the checker
// no dependencies
package bdlp_pkg;

  // counter and register width
  localparam int CNT_W = 16;
  // number of pin levels an item carries
  localparam int PIN_W = 4;
  // number of buttons reported in a result item
  localparam int REPORT_N = 4;
  // default number of buttons
  localparam int NUM_BUTTONS_DEF = 4;
  // stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd1000;

  // button report codes
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } btn_state_t;

  // item kinds
  typedef enum logic [1:0] {
    REQ_POLL      = 2'd0,
    REQ_TICK      = 2'd1,
    REQ_CLR_SHORT = 2'd2,
    REQ_CLR_LONG  = 2'd3
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_t;

  // control shared by all lanes for one item
  typedef struct packed {
    logic             fire;
    req_t             req;
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
  } lane_ctrl_t;

endpackage

// ===== rtl/core/bdlp_lane.sv =====
// bdlp_lane: per-button debounce, hold counter and press state
// depends on bdlp_pkg
module bdlp_lane
  import bdlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  logic       down,
  output btn_state_t state_next
);

  logic             latch;
  logic [CNT_W-1:0] deb_cnt;
  logic [CNT_W-1:0] hold_cnt;
  btn_state_t       state;

  logic             latch_next;
  logic [CNT_W-1:0] deb_cnt_next;
  logic [CNT_W-1:0] hold_cnt_next;

  // next values for the current item
  always_comb begin
    latch_next    = latch;
    deb_cnt_next  = deb_cnt;
    hold_cnt_next = hold_cnt;
    state_next    = state;
    if (ctrl.fire) begin
      case (ctrl.req)
        REQ_POLL: begin
          // new press latches and loads debounce
          if (down && !latch) begin
            latch_next   = 1'b1;
            deb_cnt_next = ctrl.debounce_ticks;
          end
          // debounce expiring confirms the press
          if (deb_cnt_next == CNT_W'(1)) begin
            if (down) hold_cnt_next = ctrl.long_press_ticks;
            deb_cnt_next = '0;
          end
          // release after debounce, short press if hold still running
          if (!down && deb_cnt_next == '0) begin
            if (hold_cnt_next > CNT_W'(1)) begin
              state_next    = ST_SHORT;
              hold_cnt_next = '0;
            end
            latch_next = 1'b0;
          end
        end
        REQ_TICK: begin
          if (deb_cnt > CNT_W'(1)) deb_cnt_next = deb_cnt - CNT_W'(1);
          if (hold_cnt != '0) begin
            if (hold_cnt == CNT_W'(1)) state_next = ST_LONG;
            hold_cnt_next = hold_cnt - CNT_W'(1);
          end
        end
        REQ_CLR_SHORT: begin
          if (state == ST_SHORT) state_next = ST_IDLE;
        end
        REQ_CLR_LONG: begin
          if (state == ST_LONG) state_next = ST_IDLE;
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  // lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      latch    <= 1'b0;
      deb_cnt  <= '0;
      hold_cnt <= '0;
      state    <= ST_IDLE;
    end else begin
      latch    <= latch_next;
      deb_cnt  <= deb_cnt_next;
      hold_cnt <= hold_cnt_next;
      state    <= state_next;
    end
  end

endmodule

// ===== rtl/core/bdlp_merge.sv =====
// bdlp_merge: gathers the reported lane states into the output register
// depends on bdlp_pkg
module bdlp_merge
  import bdlp_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  btn_state_t [NUM_BUTTONS-1:0]      states_next,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [OUT_DATA_W-1:0]             out_data
);

  logic [REPORT_N-1:0][1:0] report;

  // first four buttons, missing buttons read as idle
  for (genvar r = 0; r < REPORT_N; r++) begin : g_report
    if (r < NUM_BUTTONS) begin : g_have
      assign report[r] = states_next[r];
    end else begin : g_none
      assign report[r] = ST_IDLE;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= OUT_DATA_W'(report);
    end
  end

endmodule

// ===== rtl/core/button_debounce_long_press.sv =====
// button_debounce_long_press: debounce and long-press qualifier, one lane per button (four by default)
// the result of an accepted item is in the output register in the next cycle
// throughput: one item per cycle; the single output register stalls input only
// while a result waits and m_axis_tready is low
// reset (rst, synchronous): lanes idle, counters zero, registers 50 and 1000
// depends on bdlp_pkg, bdlp_lane, bdlp_merge
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side item
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [3:0] pin_levels, [7:4] zero
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] req_type
  // master side item
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [1:0] up, [3:2] down, [5:4] right, [7:6] left
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  logic [CNT_W-1:0]             debounce_ticks;
  logic [CNT_W-1:0]             long_press_ticks;
  lane_ctrl_t                   ctrl;
  logic [NUM_BUTTONS-1:0]       lane_down;
  btn_state_t [NUM_BUTTONS-1:0] states_next;
  logic                         fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RST;
      long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        CFG_LONG_PRESS: long_press_ticks <= cfg_data;
        default:        debounce_ticks   <= debounce_ticks;
      endcase
    end
  end

  // accept while the output register is free or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  // control shared by the lanes
  always_comb begin
    ctrl.fire             = fire;
    ctrl.req              = req_t'(s_axis_tuser);
    ctrl.debounce_ticks   = debounce_ticks;
    ctrl.long_press_ticks = long_press_ticks;
  end

  // one lane per button, buttons past the pins read as released
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    if (g < PIN_W) begin : g_pin
      assign lane_down[g] = ~s_axis_tdata[g];
    end else begin : g_nopin
      assign lane_down[g] = 1'b0;
    end

    bdlp_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .down       (lane_down[g]),
      .state_next (states_next[g])
    );
  end

  // merge stage and output register
  bdlp_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .states_next (states_next),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata)
  );

endmodule

// ===== rtl/core/bdlp_checker.sv =====
// bdlp_checker: port-level assertions for button_debounce_long_press
// depends on bdlp_pkg; bound to the top level below
module bdlp_checker
  import bdlp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // every accepted item gives a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // no input taken while a result is stuck
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("item accepted over a stalled result");

  // report codes stay in range
  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[3:2] != 2'd3 &&
                      m_axis_tdata[5:4] != 2'd3 && m_axis_tdata[7:6] != 2'd3)
    else $error("invalid button state code");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);
